[rtl/alsched_pkg.sv]
// Shared types and constants of the alarm slot scheduler.
// No dependencies; every other file but alsched_if.sv imports this package.
package alsched_pkg;

	localparam int SLOTS       = 16;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LATE_LIMIT  = 60;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [4:0]  NO_HOUR    = 5'd31;
	localparam logic [4:0]  HOURS_DAY  = 5'd24;
	localparam logic [3:0]  ANY_DAY    = 4'hF;
	localparam logic [24:0] ONE_SHOT   = 25'h1FFFFFF;

	typedef enum logic [1:0] {
		MODE_TICK       = 2'd0,
		MODE_ADD_HOURLY = 2'd1,
		MODE_ADD_TIMED  = 2'd2,
		MODE_CLEAR      = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		RSP_FIRED    = 2'd0,
		RSP_ADDED    = 2'd1,
		RSP_REJECTED = 2'd2,
		RSP_NONE     = 2'd3
	} rsp_code_t;

	typedef enum logic [1:0] {
		CTL_IDLE  = 2'd0,
		CTL_WALK  = 2'd1,
		CTL_FLUSH = 2'd2
	} ctl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic ready;  // take a request beat when one is offered
		logic step;   // process the current slot of the walk
		logic flush;  // emit the closing beat of a tick
	} ctl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic req_valid;  // a request beat is offered
		logic req_tick;   // the offered beat is a tick
		logic out_free;   // the output register can take a beat this cycle
		logic walk_last;  // the walk sits on the last slot
	} dp_sts_t;

endpackage

[rtl/alsched_if.sv]
// Handshake channels of the alarm slot scheduler: request and response.
// Standalone; the payload widths follow the fixed field widths.
interface alsched_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [31:0]        current_time;
	logic [2:0]         current_weekday;
	logic [4:0]         current_hour;
	logic signed [3:0]  weekday_filter;
	logic [23:0]        hour_mask;
	logic [31:0]        start_time;
	logic signed [24:0] repeat_interval;

	modport source (output valid, mode, current_time, current_weekday, current_hour,
		weekday_filter, hour_mask, start_time, repeat_interval, input ready);
	modport sink (input valid, mode, current_time, current_weekday, current_hour,
		weekday_filter, hour_mask, start_time, repeat_interval, output ready);
endinterface

interface alsched_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] slot_index;
	logic       is_last;

	modport source (output valid, status, slot_index, is_last, input ready);
	modport sink (input valid, status, slot_index, is_last, output ready);
endinterface

[rtl/alarm_slot_scheduler.sv]
// Alarm slot scheduler: a sixteen-entry table of hourly and timed alarms.
// Add and clear requests place their single beat in the output register in the cycle after
// acceptance. A tick walks the table one slot per cycle while the output register is free:
// a walk step for each of the SLOTS slots, then a closing beat. A new request is taken in
// the cycle the last beat of the previous one leaves. Reset clears the used bits, the last
// tick time and the control state at once.
module alarm_slot_scheduler (
	input logic           clk,
	input logic           arst_n,
	alsched_req_if.sink   req,
	alsched_rsp_if.source rsp
);
	import alsched_pkg::*;

	// The controller only sequences; every table access, comparison and the
	// output register live in the datapath.
	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// Controller: idle (accept requests), walk the slots, then close the tick
	// with its final beat. It advances only when the output register is free,
	// so a stalled response side freezes the walk without losing a beat.
	alsched_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath: the slot table, the per-slot evaluation, and a one-deep hold
	// of the latest firing, so that the last beat of a tick can be flagged
	// once the walk knows no later slot fires.
	alsched_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

[rtl/alsched_ctrl.sv]
// Sequencing state machine of the alarm slot scheduler.
// Depends on alsched_pkg; talks to alsched_dp through ctl_cmd_t and dp_sts_t.
module alsched_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alsched_pkg::dp_sts_t  sts,
	output alsched_pkg::ctl_cmd_t cmd
);
	import alsched_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CTL_IDLE: begin
				if (sts.req_valid && sts.out_free && sts.req_tick) begin
					state_d = CTL_WALK;
				end
			end
			CTL_WALK: begin
				if (sts.out_free && sts.walk_last) begin
					state_d = CTL_FLUSH;
				end
			end
			CTL_FLUSH: begin
				if (sts.out_free) begin
					state_d = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			CTL_IDLE:  cmd.ready = sts.out_free;
			CTL_WALK:  cmd.step  = sts.out_free;
			CTL_FLUSH: cmd.flush = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

[rtl/alsched_dp.sv]
// Datapath of the alarm slot scheduler: slot table, walk logic, output register.
// Depends on alsched_pkg and the alsched_req_if / alsched_rsp_if channels.
module alsched_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	alsched_req_if.sink           req,
	alsched_rsp_if.source         rsp,
	input  alsched_pkg::ctl_cmd_t cmd,
	output alsched_pkg::dp_sts_t  sts
);
	import alsched_pkg::*;

	// Slot table. Only the used bits are reset; the fields are written by an add
	// before any tick can read them.
	logic [SLOTS-1:0] used_q;
	logic             kind_q     [SLOTS];
	logic [3:0]       wday_q     [SLOTS];
	logic [23:0]      hours_q    [SLOTS];
	logic [4:0]       last_hour_q[SLOTS];
	logic [31:0]      due_q      [SLOTS];
	logic [24:0]      ival_q     [SLOTS];
	logic             fin_q      [SLOTS];
	logic [31:0]      last_tick_q;

	// Tick being walked.
	logic [31:0]       cur_q;
	logic [2:0]        tick_wday_q;
	logic [4:0]        tick_hour_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_valid_q;
	logic [SLOT_W-1:0] pend_idx_q;

	// Output register.
	logic       out_valid_q;
	logic [1:0] out_status_q;
	logic [3:0] out_slot_q;
	logic       out_last_q;

	logic load;
	logic out_free;

	assign out_free  = !out_valid_q || rsp.ready;
	assign load      = req.valid && cmd.ready;
	assign req.ready = cmd.ready;

	assign sts.req_valid = req.valid;
	assign sts.req_tick  = (req.mode == MODE_TICK);
	assign sts.out_free  = out_free;
	assign sts.walk_last = (idx_q == SLOT_W'(SLOTS - 1));

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot_index = out_slot_q;
	assign rsp.is_last    = out_last_q;

	// Lowest free slot for an add.
	logic              have_free;
	logic [SLOT_W-1:0] free_idx;

	always_comb begin
		have_free = 1'b0;
		free_idx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				have_free = 1'b1;
				free_idx  = SLOT_W'(i);
			end
		end
	end

	// Evaluation of the slot under the walk pointer.
	logic        s_used, s_kind, s_fin;
	logic [31:0] s_due;
	logic [24:0] s_ival;
	logic [31:0] hours_ext;
	logic        wmatch, listed;
	logic        cur_ge_due;
	logic [31:0] late_gap;
	logic        fire;
	logic        wr_hour;
	logic [4:0]  new_hour;
	logic        wr_due;
	logic [31:0] new_due;
	logic        set_fin;
	logic        release_slot;

	always_comb begin
		s_used     = used_q[idx_q];
		s_kind     = kind_q[idx_q];
		s_fin      = fin_q[idx_q];
		s_due      = due_q[idx_q];
		s_ival     = ival_q[idx_q];
		hours_ext  = {8'h00, hours_q[idx_q]};
		wmatch     = (wday_q[idx_q] == ANY_DAY) || (wday_q[idx_q] == {1'b0, tick_wday_q});
		listed     = (tick_hour_q < HOURS_DAY) && hours_ext[tick_hour_q];
		cur_ge_due = (cur_q >= s_due);
		late_gap   = cur_q - s_due;
		new_due    = cur_q + {{7{s_ival[24]}}, s_ival};

		fire         = 1'b0;
		wr_hour      = 1'b0;
		new_hour     = listed ? tick_hour_q : NO_HOUR;
		wr_due       = 1'b0;
		set_fin      = 1'b0;
		release_slot = 1'b0;

		if (s_used) begin
			if (!s_kind) begin
				// Hourly: fire on entering a listed hour, re-arm when unlisted.
				if (wmatch) begin
					wr_hour = 1'b1;
					fire    = listed && (last_hour_q[idx_q] != tick_hour_q);
				end
			end else if (s_fin) begin
				release_slot = 1'b1;
			end else if (cur_ge_due) begin
				if (s_ival == ONE_SHOT) begin
					set_fin = 1'b1;
					fire    = (late_gap <= 32'(LATE_LIMIT));
				end else begin
					wr_due = 1'b1;
					fire   = 1'b1;
				end
			end
		end
	end

	logic report;
	assign report = cmd.step && fire && (cnt_q < CNT_W'(MAX_RESULTS));

	logic add_hourly_ok, add_timed_ok;
	assign add_hourly_ok = load && (req.mode == MODE_ADD_HOURLY) && have_free
		&& (req.hour_mask != '0);
	assign add_timed_ok  = load && (req.mode == MODE_ADD_TIMED) && have_free;

	// Slot fields: no reset.
	always_ff @(posedge clk) begin
		if (add_hourly_ok) begin
			kind_q[free_idx]      <= 1'b0;
			wday_q[free_idx]      <= req.weekday_filter;
			hours_q[free_idx]     <= req.hour_mask;
			last_hour_q[free_idx] <= NO_HOUR;
		end
		if (add_timed_ok) begin
			kind_q[free_idx] <= 1'b1;
			due_q[free_idx]  <= (req.start_time == '0) ? last_tick_q : req.start_time;
			ival_q[free_idx] <= req.repeat_interval;
			fin_q[free_idx]  <= 1'b0;
		end
		if (cmd.step) begin
			if (wr_hour) begin
				last_hour_q[idx_q] <= new_hour;
			end
			if (wr_due) begin
				due_q[idx_q] <= new_due;
			end
			if (set_fin) begin
				fin_q[idx_q] <= 1'b1;
			end
		end
	end

	// Tick operands and pending result: payload only.
	always_ff @(posedge clk) begin
		if (load && (req.mode == MODE_TICK)) begin
			cur_q       <= req.current_time;
			tick_wday_q <= req.current_weekday;
			tick_hour_q <= req.current_hour;
		end
		if (report) begin
			pend_idx_q <= idx_q;
		end
	end

	// Control state and registered output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			last_tick_q  <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= RSP_NONE;
			out_slot_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (load) begin
				case (req.mode)
					MODE_TICK: begin
						last_tick_q  <= req.current_time;
						idx_q        <= '0;
						cnt_q        <= '0;
						pend_valid_q <= 1'b0;
					end
					MODE_ADD_HOURLY, MODE_ADD_TIMED: begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b1;
						if (add_hourly_ok || add_timed_ok) begin
							used_q[free_idx] <= 1'b1;
							out_status_q     <= RSP_ADDED;
							out_slot_q       <= 4'(free_idx);
						end else begin
							out_status_q <= RSP_REJECTED;
							out_slot_q   <= '0;
						end
					end
					MODE_CLEAR: begin
						used_q       <= '0;
						out_valid_q  <= 1'b1;
						out_status_q <= RSP_NONE;
						out_slot_q   <= '0;
						out_last_q   <= 1'b1;
					end
					default: begin
						out_valid_q <= 1'b0;
					end
				endcase
			end

			if (cmd.step) begin
				idx_q <= idx_q + SLOT_W'(1);
				if (release_slot) begin
					used_q[idx_q] <= 1'b0;
				end
				if (report) begin
					cnt_q        <= cnt_q + CNT_W'(1);
					pend_valid_q <= 1'b1;
					// A newer firing proves the held one is not the last beat.
					if (pend_valid_q) begin
						out_valid_q  <= 1'b1;
						out_status_q <= RSP_FIRED;
						out_slot_q   <= 4'(pend_idx_q);
						out_last_q   <= 1'b0;
					end
				end
			end

			if (cmd.flush) begin
				out_valid_q  <= 1'b1;
				out_last_q   <= 1'b1;
				pend_valid_q <= 1'b0;
				if (pend_valid_q) begin
					out_status_q <= RSP_FIRED;
					out_slot_q   <= 4'(pend_idx_q);
				end else begin
					out_status_q <= RSP_NONE;
					out_slot_q   <= '0;
				end
			end
		end
	end

endmodule
